// File: rtl/hdfs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdfs_pkg
// Shared types and constants of the 1D explicit heat step block.
// ---------------------------------------------------------------------------
package hdfs_pkg;

	localparam int ROW_DEPTH  = 64;
	localparam int NODE_W     = 6;
	localparam int TEMP_W     = 32;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = 7;
	localparam int PIPE_DEPTH = 3;

	localparam logic [NODE_W-1:0] MAX_NODES = 6'd63;
	localparam logic [NODE_W-1:0] MIN_NODES = 6'd2;

	localparam logic [COEF_W-1:0] COEF_RESET  = 16'd16384;
	localparam logic [NODE_W-1:0] NODES_RESET = 6'd32;

	localparam logic MODE_STEP = 1'b1;

	typedef logic signed [TEMP_W-1:0] hdfs_temp_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIFFUSION = 2'd0,
		CFG_NODES     = 2'd1,
		CFG_INIT_TEMP = 2'd2
	} hdfs_cfg_idx_t;

	// where the new node value comes from
	typedef enum logic [1:0] {
		SRC_LEFT,
		SRC_RIGHT,
		SRC_INIT,
		SRC_STEP
	} hdfs_src_t;

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
		logic              last;
		hdfs_src_t         src;
	} hdfs_tag_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} hdfs_state_t;

endpackage

// File: rtl/hdfs_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdfs channel interfaces
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
interface hdfs_in_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic signed [hdfs_pkg::TEMP_W-1:0] left_boundary;
	logic signed [hdfs_pkg::TEMP_W-1:0] right_boundary;

	modport source (output valid, mode, left_boundary, right_boundary, input ready);
	modport sink (input valid, mode, left_boundary, right_boundary, output ready);
endinterface

interface hdfs_out_if;
	logic                               valid;
	logic                               ready;
	logic [hdfs_pkg::NODE_W-1:0]        node_index;
	logic signed [hdfs_pkg::TEMP_W-1:0] temperature;
	logic                               last_in_row;

	modport source (output valid, node_index, temperature, last_in_row, input ready);
	modport sink (input valid, node_index, temperature, last_in_row, output ready);
endinterface

interface hdfs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hdfs_pkg::CFG_IDX_W-1:0] index;
	logic [hdfs_pkg::TEMP_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hdfs_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdfs_cell
// One node of the temperature row; shifts toward node 0 or takes the tail.
// ---------------------------------------------------------------------------
module hdfs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic                sel_tail,
	input  hdfs_pkg::hdfs_temp_t nbr,
	input  hdfs_pkg::hdfs_temp_t tail,
	output hdfs_pkg::hdfs_temp_t q
);

	hdfs_pkg::hdfs_temp_t temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
		end else if (shift_en) begin
			temp_q <= sel_tail ? tail : nbr;
		end
	end

	assign q = temp_q;

endmodule

// File: rtl/hdfs_pe.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdfs_pe
// Stencil pipeline: neighbor sum, two products, round/saturate into the
// output register. Sits in the ring between node 0 and the tail node.
// ---------------------------------------------------------------------------
module hdfs_pe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  hdfs_pkg::hdfs_tag_t               tag_in,
	input  hdfs_pkg::hdfs_temp_t              centre,
	input  hdfs_pkg::hdfs_temp_t              right_nbr,
	input  logic [hdfs_pkg::COEF_W-1:0]       coef,
	input  hdfs_pkg::hdfs_temp_t              left_val,
	input  hdfs_pkg::hdfs_temp_t              right_val,
	input  hdfs_pkg::hdfs_temp_t              init_val,
	output hdfs_pkg::hdfs_tag_t               tag_out,
	output hdfs_pkg::hdfs_temp_t              temp_out
);

	localparam int SUM_W  = hdfs_pkg::TEMP_W + 1;
	localparam int PROD_W = 50;
	localparam int ACC_W  = PROD_W + 1;
	localparam int FRAC_W = 16;
	localparam int RND_W  = ACC_W - FRAC_W;

	hdfs_pkg::hdfs_tag_t  tag_s1, tag_s2, tag_q;
	hdfs_pkg::hdfs_temp_t centre_s1;
	logic signed [SUM_W-1:0]  side_s1;
	logic signed [PROD_W-1:0] p_side_s2, p_mid_s2;
	hdfs_pkg::hdfs_temp_t temp_q;

	logic signed [hdfs_pkg::COEF_W:0]   coef_s;
	logic signed [hdfs_pkg::COEF_W+1:0] centre_w;
	logic signed [ACC_W-1:0]            acc;
	logic signed [RND_W-1:0]            rnd;
	hdfs_pkg::hdfs_temp_t               step_val;
	hdfs_pkg::hdfs_temp_t               new_val;

	// centre weight 1-2c as signed Q1.16
	assign coef_s   = $signed({1'b0, coef});
	assign centre_w = 18'sd65536 - $signed({1'b0, coef, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_q  <= '0;
			temp_q <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_q  <= tag_s2;
			temp_q <= new_val;
		end
	end

	// centre_s1 still holds the node to the left when the next node arrives
	always_ff @(posedge clk) begin
		if (adv) begin
			centre_s1 <= centre;
			side_s1   <= SUM_W'(centre_s1) + SUM_W'(right_nbr);
			p_side_s2 <= PROD_W'(coef_s) * PROD_W'(side_s1);
			p_mid_s2  <= PROD_W'(centre_w) * PROD_W'(centre_s1);
		end
	end

	// round half up, floor by arithmetic shift, then clip to Q15.16
	always_comb begin
		acc = ACC_W'(p_side_s2) + ACC_W'(p_mid_s2) + ACC_W'(32768);
		rnd = acc[ACC_W-1:FRAC_W];
		if (rnd > RND_W'(64'sh7FFF_FFFF)) begin
			step_val = 32'sh7FFF_FFFF;
		end else if (rnd < -RND_W'(64'sh8000_0000)) begin
			step_val = 32'sh8000_0000;
		end else begin
			step_val = rnd[hdfs_pkg::TEMP_W-1:0];
		end
	end

	always_comb begin
		case (tag_s2.src)
			hdfs_pkg::SRC_LEFT:  new_val = left_val;
			hdfs_pkg::SRC_RIGHT: new_val = right_val;
			hdfs_pkg::SRC_INIT:  new_val = init_val;
			hdfs_pkg::SRC_STEP:  new_val = step_val;
			default:             new_val = step_val;
		endcase
	end

	assign tag_out  = tag_q;
	assign temp_out = temp_q;

	ap_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tag_q.last |-> tag_q.valid)
		else $error("last flag on an empty output stage");

	ap_edge_src: assert property (@(posedge clk) disable iff (!arst_n)
		tag_q.valid && tag_q.node == '0 |-> tag_q.src == hdfs_pkg::SRC_LEFT)
		else $error("node 0 not taken from the left boundary");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tag_q) && $stable(temp_q))
		else $error("output stage moved without advance");

endmodule

// File: rtl/heat_diffusion_ftcs_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heat_diffusion_ftcs_step
// Explicit forward-time centred-space 1D heat step over a ring of node cells.
//
// channel  role  handshake      beat carries
// cfg      sink  valid/ready    index, data
// in_ch    sink  valid/ready    mode, left_boundary, right_boundary
// out_ch   src   valid/ready    node_index, temperature, last_in_row
//
// N = active_nodes clamped to 2..63 (32 at reset). Once an item is accepted,
// the N+1 row cells and the three stencil stages form one ring that turns once.
// One result beat leaves per cycle; a stalled out_ch freezes the whole ring.
// in_ch is taken only between items; cfg is always ready.
// Reset clears the row to zero and loads the register defaults.
// ---------------------------------------------------------------------------
module heat_diffusion_ftcs_step (
	input  logic          clk,
	input  logic          arst_n,
	hdfs_cfg_if.sink      cfg,
	hdfs_in_if.sink       in_ch,
	hdfs_out_if.source    out_ch
);

	hdfs_pkg::hdfs_state_t state_q, state_nxt;

	logic [hdfs_pkg::COEF_W-1:0]  coef_q;
	logic [hdfs_pkg::NODE_W-1:0]  nodes_q;
	hdfs_pkg::hdfs_temp_t         init_q;
	hdfs_pkg::hdfs_temp_t         left_q, right_q;
	logic                         mode_q;
	logic [hdfs_pkg::NODE_W-1:0]  n_q;
	logic [hdfs_pkg::CNT_W-1:0]   k_q;

	logic [hdfs_pkg::NODE_W-1:0]  n_clamp;
	logic                         in_fire, running, adv, done;
	hdfs_pkg::hdfs_tag_t          tag_in, tag_out;
	hdfs_pkg::hdfs_temp_t         temp_out;
	hdfs_pkg::hdfs_temp_t         row [hdfs_pkg::ROW_DEPTH];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= hdfs_pkg::COEF_RESET;
			nodes_q <= hdfs_pkg::NODES_RESET;
			init_q  <= '0;
		end else if (cfg.valid) begin
			case (hdfs_pkg::hdfs_cfg_idx_t'(cfg.index))
				hdfs_pkg::CFG_DIFFUSION: coef_q  <= cfg.data[hdfs_pkg::COEF_W-1:0];
				hdfs_pkg::CFG_NODES:     nodes_q <= cfg.data[hdfs_pkg::NODE_W-1:0];
				hdfs_pkg::CFG_INIT_TEMP: init_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nodes_q < hdfs_pkg::MIN_NODES) begin
			n_clamp = hdfs_pkg::MIN_NODES;
		end else if (nodes_q > hdfs_pkg::MAX_NODES) begin
			n_clamp = hdfs_pkg::MAX_NODES;
		end else begin
			n_clamp = nodes_q;
		end
	end

	assign in_fire = in_ch.valid && in_ch.ready;
	assign adv     = running && (!tag_out.valid || out_ch.ready);
	assign done    = adv && (k_q == hdfs_pkg::CNT_W'(n_q) + hdfs_pkg::CNT_W'(hdfs_pkg::PIPE_DEPTH));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hdfs_pkg::ST_IDLE: begin
				if (in_fire) state_nxt = hdfs_pkg::ST_RUN;
			end
			hdfs_pkg::ST_RUN: begin
				if (done) state_nxt = hdfs_pkg::ST_IDLE;
			end
			default: state_nxt = hdfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			hdfs_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				running     = 1'b0;
			end
			hdfs_pkg::ST_RUN: begin
				in_ch.ready = 1'b0;
				running     = 1'b1;
			end
			default: begin
				in_ch.ready = 1'b0;
				running     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdfs_pkg::ST_IDLE;
			k_q     <= '0;
			n_q     <= hdfs_pkg::NODES_RESET;
			mode_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire) begin
				k_q    <= '0;
				n_q    <= n_clamp;
				mode_q <= in_ch.mode;
			end else if (adv) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			left_q  <= in_ch.left_boundary;
			right_q <= in_ch.right_boundary;
		end
	end

	// node k enters the stencil pipe on the k-th turn; later turns are bubbles
	always_comb begin
		tag_in.valid = (k_q <= hdfs_pkg::CNT_W'(n_q));
		tag_in.node  = k_q[hdfs_pkg::NODE_W-1:0];
		tag_in.last  = (k_q == hdfs_pkg::CNT_W'(n_q));
		if (k_q == '0) begin
			tag_in.src = hdfs_pkg::SRC_LEFT;
		end else if (tag_in.last) begin
			tag_in.src = hdfs_pkg::SRC_RIGHT;
		end else if (mode_q == hdfs_pkg::MODE_STEP) begin
			tag_in.src = hdfs_pkg::SRC_STEP;
		end else begin
			tag_in.src = hdfs_pkg::SRC_INIT;
		end
	end

	// cells 0..N rotate toward node 0; cell N takes the pipe output
	for (genvar j = 0; j < hdfs_pkg::ROW_DEPTH; j++) begin : g_cell
		hdfs_pkg::hdfs_temp_t nbr;
		if (j == hdfs_pkg::ROW_DEPTH - 1) begin : g_end
			assign nbr = temp_out;
		end else begin : g_mid
			assign nbr = row[j+1];
		end
		hdfs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (adv && (hdfs_pkg::NODE_W'(j) <= n_q)),
			.sel_tail (hdfs_pkg::NODE_W'(j) == n_q),
			.nbr      (nbr),
			.tail     (temp_out),
			.q        (row[j])
		);
	end

	hdfs_pe u_pe (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tag_in    (tag_in),
		.centre    (row[0]),
		.right_nbr (row[1]),
		.coef      (coef_q),
		.left_val  (left_q),
		.right_val (right_q),
		.init_val  (init_q),
		.tag_out   (tag_out),
		.temp_out  (temp_out)
	);

	assign out_ch.valid       = tag_out.valid;
	assign out_ch.node_index  = tag_out.node;
	assign out_ch.temperature = temp_out;
	assign out_ch.last_in_row = tag_out.last;

	ap_out_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> state_q == hdfs_pkg::ST_RUN)
		else $error("result beat outside an item");

	ap_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == hdfs_pkg::ST_RUN && k_q == '0)
		else $error("item accepted without starting the ring");

	ap_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.last_in_row |=> state_q == hdfs_pkg::ST_IDLE)
		else $error("ring still turning after the last beat");

	ap_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.node_index <= n_q)
		else $error("node index beyond the row");

endmodule

// File: bench/hdfs_row_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdfs_row_checker
// Watches the register, item and result channels of the heat step block.
// Keeps its own copy of the registers and of the node row, works out the
// full new row for every accepted item and compares each result beat,
// field by field, with the oldest node still owed.
// ---------------------------------------------------------------------------
module hdfs_row_checker
	import hdfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hdfs_cfg_if         cfg,
	hdfs_in_if          in_ch,
	hdfs_out_if         out_ch,
	output int unsigned beats_owed,
	output int unsigned mismatches
);

	localparam longint TEMP_MAX = (64'sd1 <<< (TEMP_W - 1)) - 1;
	localparam longint TEMP_MIN = -(64'sd1 <<< (TEMP_W - 1));

	typedef struct {
		logic [NODE_W-1:0] node;
		hdfs_temp_t        temp;
		logic              last;
	} node_temp_t;

	logic [COEF_W-1:0] coef_q;
	logic [NODE_W-1:0] last_node_q;
	hdfs_temp_t        init_temp_q;
	hdfs_temp_t        heat_row [ROW_DEPTH];
	node_temp_t        owed_q [$];

	always @(posedge clk or negedge arst_n) begin
		int unsigned n;
		longint      coef;
		longint      centre_w;
		longint      acc;
		longint      rounded;
		hdfs_temp_t  next_row [ROW_DEPTH];
		node_temp_t  want;
		if (!arst_n) begin
			coef_q      = COEF_RESET;
			last_node_q = NODES_RESET;
			init_temp_q = '0;
			for (int j = 0; j < ROW_DEPTH; j++)
				heat_row[j] = '0;
			owed_q.delete();
			mismatches = 0;
			beats_owed <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DIFFUSION: coef_q = cfg.data[COEF_W-1:0];
					CFG_NODES:     last_node_q = cfg.data[NODE_W-1:0];
					CFG_INIT_TEMP: init_temp_q = cfg.data;
					default: ; // spare index, nothing behind it
				endcase
			end

			if (in_ch.valid && in_ch.ready) begin
				n = (last_node_q < MIN_NODES) ? MIN_NODES :
					(last_node_q > MAX_NODES) ? MAX_NODES : last_node_q;
				coef     = longint'(coef_q);
				centre_w = 65536 - 2 * coef;
				for (int j = 1; j < n; j++) begin
					if (in_ch.mode == MODE_STEP) begin
						// q.32 sum, round half up to q15.16, then clamp
						acc = coef * (longint'(heat_row[j+1]) + longint'(heat_row[j-1]))
							+ centre_w * longint'(heat_row[j]);
						rounded = (acc + 32768) >>> 16;
						rounded = (rounded > TEMP_MAX) ? TEMP_MAX :
							(rounded < TEMP_MIN) ? TEMP_MIN : rounded;
						next_row[j] = rounded[TEMP_W-1:0];
					end else begin
						next_row[j] = init_temp_q;
					end
				end
				next_row[0] = in_ch.left_boundary;
				next_row[n] = in_ch.right_boundary;
				for (int j = 0; j <= n; j++) begin
					heat_row[j] = next_row[j];
					want.node   = NODE_W'(j);
					want.temp   = next_row[j];
					want.last   = (j == n);
					owed_q.insert(owed_q.size(), want);
				end
			end

			if (out_ch.valid && out_ch.ready) begin
				if (owed_q.size() == 0) begin
					$error("result beat with no node owed: node_index %0d temperature %0d",
						out_ch.node_index, out_ch.temperature);
					mismatches++;
				end else begin
					want = owed_q.pop_front();
					if (out_ch.node_index !== want.node) begin
						$error("node_index: expected %0d, got %0d", want.node,
							out_ch.node_index);
						mismatches++;
					end
					if (out_ch.temperature !== want.temp) begin
						$error("temperature (node %0d): expected %0d, got %0d", want.node,
							want.temp, out_ch.temperature);
						mismatches++;
					end
					if (out_ch.last_in_row !== want.last) begin
						$error("last_in_row (node %0d): expected %0b, got %0b", want.node,
							want.last, out_ch.last_in_row);
						mismatches++;
					end
				end
			end

			beats_owed <= owed_q.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 1D explicit heat step block.
// A directed pass covers the field extremes, both item kinds, clamped node
// counts, the spare register index, an unstable coefficient, exact rounding
// halves and a row grown after a load. Random phases follow, each with fresh
// register values and its own mix of sender gaps and receiver stalls, one of
// them with a long receiver hold-off. The checker beside the block predicts
// and compares every result beat.
// ---------------------------------------------------------------------------
module tb_top;
	import hdfs_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 16;
	localparam int TAIL_CYCLES     = 80;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 18;
	localparam int IDLE_HEAVY      = 86;
	localparam int IDLE_LIGHT      = 8;

	localparam logic                 MODE_LOAD = ~MODE_STEP;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        long_hold = 1'b0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned beats_owed;
	int unsigned mismatches;
	int unsigned quiet_cycles = 0;

	hdfs_cfg_if cfg_ch ();
	hdfs_in_if  in_ch ();
	hdfs_out_if out_ch ();

	heat_diffusion_ftcs_step i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	hdfs_row_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.beats_owed (beats_owed),
		.mismatches (mismatches)
	);

	always #4 clk = ~clk;

	function automatic hdfs_temp_t rand_temp();
		hdfs_temp_t t;
		t = hdfs_temp_t'($urandom);
		return t >>> $urandom_range(28);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic mode, input hdfs_temp_t left, input hdfs_temp_t right);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.mode           <= mode;
		in_ch.left_boundary  <= left;
		in_ch.right_boundary <= right;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// stop offering, let every owed node arrive and the ring come to rest
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (beats_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$error("no beat on any channel for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n               <= 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.mode           <= MODE_LOAD;
		in_ch.left_boundary  <= '0;
		in_ch.right_boundary <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= CFG_DIFFUSION;
		cfg_ch.data          <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero row straight out of reset, default coefficient and length
		send_item(MODE_STEP, 32'sh0000_0000, 32'sh0000_0000);
		send_item(MODE_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
		send_item(MODE_STEP, 32'sh0000_0001, 32'shffff_ffff);
		send_item(MODE_STEP, 32'sh8000_0000, 32'sh7fff_ffff);
		wait_idle();

		// unstable coefficient over the longest row drives nodes into saturation
		write_reg(CFG_DIFFUSION, 32'h0000_ffff);
		write_reg(CFG_NODES, 32'd63);
		write_reg(CFG_INIT_TEMP, 32'h7fff_ffff);
		send_item(MODE_LOAD, 32'sh8000_0000, 32'sh7fff_ffff);
		send_item(MODE_STEP, 32'sh8000_0000, 32'sh8000_0000);
		send_item(MODE_STEP, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_item(MODE_STEP, 32'sh5555_5555, 32'shaaaa_aaaa);
		wait_idle();

		// zero coefficient, node counts below the minimum, spare register index
		write_reg(CFG_DIFFUSION, 32'h0000_0000);
		write_reg(CFG_NODES, 32'd0);
		write_reg(CFG_INIT_TEMP, 32'h8000_0000);
		send_item(MODE_LOAD, 32'sh1234_5678, 32'shedcb_a987);
		send_item(MODE_STEP, 32'shffff_0000, 32'sh0001_0000);
		wait_idle();
		write_reg(CFG_NODES, 32'd1);
		write_reg(CFG_SPARE, 32'hffff_ffff);
		send_item(MODE_STEP, 32'sh0000_ffff, 32'shffff_8000);
		wait_idle();

		// half coefficient: centre weight is zero, odd neighbor sums give exact halves
		write_reg(CFG_DIFFUSION, 32'h0000_8000);
		write_reg(CFG_NODES, 32'd2);
		send_item(MODE_LOAD, 32'sh0000_0001, -32'sd2);
		send_item(MODE_STEP, 32'sh0000_0003, 32'sh0000_0000);
		send_item(MODE_STEP, 32'sh0000_0005, -32'sd2);
		wait_idle();

		// row grown after a load picks up zeros and stale nodes past the old end
		write_reg(CFG_DIFFUSION, 32'h0000_1000);
		write_reg(CFG_NODES, 32'd5);
		write_reg(CFG_INIT_TEMP, 32'h0001_0000);
		send_item(MODE_LOAD, 32'sh0064_0000, 32'shff9c_0000);
		wait_idle();
		write_reg(CFG_NODES, 32'd12);
		send_item(MODE_STEP, 32'sh0064_0000, 32'shff9c_0000);
		send_item(MODE_STEP, 32'sh0000_0000, 32'sh0000_0000);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = IDLE_HEAVY;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = IDLE_HEAVY;
				end
				default: begin
					src_idle_pct  = IDLE_LIGHT;
					snk_stall_pct = IDLE_LIGHT;
				end
			endcase
			write_reg(CFG_DIFFUSION,
				($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(32768));
			write_reg(CFG_NODES,
				($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(12));
			write_reg(CFG_INIT_TEMP, rand_temp());
			// a load opens each phase, then mostly steps with the odd reload
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 0 && k == 4)
					long_hold = 1'b1;
				send_item((k == 0 || $urandom_range(5) == 0) ? MODE_LOAD : MODE_STEP,
					rand_temp(), rand_temp());
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
